### rtl/emp_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the energy pulse meter.
package emp_pkg;

    localparam logic [31:0] NUMERATOR_RESET = 32'd1125000;
    localparam logic [31:0] MS_PER_SEC      = 32'd1000;
    localparam logic [15:0] SAT16           = 16'hFFFF;
    localparam logic [4:0]  HOUR_MIDNIGHT   = 5'd0;
    localparam logic [4:0]  DAY_FIRST       = 5'd1;

    // ceil(2^38 / 1000): (x * MS_RECIP) >> 38 equals x / 1000 for any 32-bit x
    localparam logic [31:0] MS_RECIP        = 32'h10624DD3;
    localparam int          MS_RECIP_SHIFT  = 38;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int DIV_STEPS   = 32;
    localparam int DIV_CW      = $clog2(DIV_STEPS);

    // Raw input kind codes
    localparam logic [1:0] KIND_PULSE  = 2'd0;
    localparam logic [1:0] KIND_POLL   = 2'd1;
    localparam logic [1:0] KIND_PRESET = 2'd2;

    typedef enum logic [1:0] {
        OP_PULSE,
        OP_POLL,
        OP_PRESET,
        OP_NONE
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_DONE
    } t_back_state;

    typedef struct packed {
        t_op         op;
        logic [31:0] now_ms;
        logic [4:0]  hour;
        logic [4:0]  month_day;
        logic        time_valid;
        logic [31:0] preset_count;
    } t_item;

    typedef struct packed {
        logic [15:0] power_watts;
        logic [15:0] idle_seconds;
        logic [31:0] total_pulses;
        logic [31:0] day_pulses;
        logic [31:0] month_pulses;
    } t_result;

    typedef struct packed {
        logic start;
        logic done;
    } t_div_ctl;

    function automatic logic [15:0] sat16(input logic [31:0] v);
        logic [15:0] r;
        r = (|v[31:16]) ? SAT16 : v[15:0];
        return r;
    endfunction

endpackage

### rtl/energy_pulse_meter_top.sv
`timescale 1ns / 1ps
// Energy pulse meter: input queue, iterative power divider, meter state, result register.
// Each item passes the queue, the divider and the result register before it shows.
// The back end takes one item at a time through the 32-step radix-2 divider.
// Up to 4 items queue in front while the back end works or the result waits.
// Reset (synchronous, active low): counts, stamps, last pulse time and power clear to 0,
// the numerator returns to 1125000, the queue and result register empty.
module energy_pulse_meter_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         push,
    output logic         full,
    input  logic [1:0]   i_kind,
    input  logic [31:0]  i_now_ms,
    input  logic [4:0]   i_hour,
    input  logic [4:0]   i_month_day,
    input  logic         i_time_valid,
    input  logic [31:0]  i_preset_count,
    output logic         empty,
    input  logic         pop,
    output logic [15:0]  o_power_watts,
    output logic [15:0]  o_idle_seconds,
    output logic [31:0]  o_total_pulses,
    output logic [31:0]  o_day_pulses,
    output logic [31:0]  o_month_pulses,
    input  logic         i_cfg_we,
    input  logic [31:0]  i_cfg_wdata
);

    logic                q_valid;
    emp_pkg::t_item      q_item;
    logic                q_pop;
    emp_pkg::t_div_ctl   div_start;
    emp_pkg::t_div_ctl   div_done;
    logic                div_fin;
    logic [31:0]         div_num;
    logic [31:0]         div_period;
    logic [31:0]         power_q;
    logic [31:0]         idle_q;
    logic                back_busy;
    logic                out_valid;
    emp_pkg::t_result    out_data;

    emp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_kind         (i_kind),
        .i_now_ms       (i_now_ms),
        .i_hour         (i_hour),
        .i_month_day    (i_month_day),
        .i_time_valid   (i_time_valid),
        .i_preset_count (i_preset_count),
        .o_q_valid      (q_valid),
        .o_q_item       (q_item),
        .i_q_pop        (q_pop)
    );

    emp_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start.start),
        .i_num     (div_num),
        .i_den     (div_period),
        .i_period  (div_period),
        .o_done    (div_fin),
        .o_power_q (power_q),
        .o_idle_q  (idle_q)
    );

    assign div_done = {div_start.start, div_fin};

    emp_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_q_valid       (q_valid),
        .i_q_item        (q_item),
        .o_q_pop         (q_pop),
        .o_div_ctl_start (div_start),
        .i_div_ctl_done  (div_done),
        .o_div_num       (div_num),
        .o_div_period    (div_period),
        .i_power_q       (power_q),
        .i_idle_q        (idle_q),
        .o_busy          (back_busy),
        .o_out_valid     (out_valid),
        .o_out           (out_data),
        .i_pop           (pop)
    );

    assign empty          = !out_valid;
    assign o_power_watts  = out_data.power_watts;
    assign o_idle_seconds = out_data.idle_seconds;
    assign o_total_pulses = out_data.total_pulses;
    assign o_day_pulses   = out_data.day_pulses;
    assign o_month_pulses = out_data.month_pulses;

`ifndef ASSERT_OFF
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queue or result not empty after reset");

    a_pop_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("back end took an item from an empty queue");

    a_no_phantom_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (empty && !q_valid && !back_busy) |=> empty)
        else $error("result appeared with no item in flight");

    a_done_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done.done |-> (back_busy && !div_start.start))
        else $error("divider finished while back end idle or restarting");
`endif

endmodule

### rtl/emp_front.sv
`timescale 1ns / 1ps
// Front end: accepts input beats, classifies them and queues them for the back end.
module emp_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [1:0]           i_kind,
    input  logic [31:0]          i_now_ms,
    input  logic [4:0]           i_hour,
    input  logic [4:0]           i_month_day,
    input  logic                 i_time_valid,
    input  logic [31:0]          i_preset_count,
    output logic                 o_q_valid,
    output emp_pkg::t_item       o_q_item,
    input  logic                 i_q_pop
);

    emp_pkg::t_item                  r_mem [emp_pkg::QUEUE_DEPTH];
    logic [emp_pkg::QUEUE_AW-1:0]    r_wr_ptr;
    logic [emp_pkg::QUEUE_AW-1:0]    r_rd_ptr;
    logic [emp_pkg::QUEUE_AW:0]      r_count;
    logic [emp_pkg::QUEUE_AW-1:0]    n_wr_ptr;
    logic [emp_pkg::QUEUE_AW-1:0]    n_rd_ptr;
    logic [emp_pkg::QUEUE_AW:0]      n_count;
    emp_pkg::t_item                  in_item;
    emp_pkg::t_op                    in_op;
    logic                            do_push;
    logic                            do_pop;

    always_comb begin
        case (i_kind)
            emp_pkg::KIND_PULSE:  in_op = emp_pkg::OP_PULSE;
            emp_pkg::KIND_POLL:   in_op = emp_pkg::OP_POLL;
            emp_pkg::KIND_PRESET: in_op = emp_pkg::OP_PRESET;
            default:              in_op = emp_pkg::OP_NONE;
        endcase
    end

    always_comb begin
        in_item.op           = in_op;
        in_item.now_ms       = i_now_ms;
        in_item.hour         = i_hour;
        in_item.month_day    = i_month_day;
        in_item.time_valid   = i_time_valid;
        in_item.preset_count = i_preset_count;
    end

    assign full      = (r_count == (emp_pkg::QUEUE_AW + 1)'(emp_pkg::QUEUE_DEPTH));
    assign o_q_valid = (r_count != '0);
    assign o_q_item  = r_mem[r_rd_ptr];
    assign do_push   = push && !full;
    assign do_pop    = i_q_pop && o_q_valid;

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= in_item;
        end
    end

endmodule

### rtl/emp_div.sv
`timescale 1ns / 1ps
// Radix-2 restoring divider for numerator by period; period by 1000 through a reciprocal multiply.
module emp_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [31:0]       i_num,
    input  logic [31:0]       i_den,
    input  logic [31:0]       i_period,
    output logic              o_done,
    output logic [31:0]       o_power_q,
    output logic [31:0]       o_idle_q
);

    logic                        r_busy;
    logic                        r_done;
    logic [emp_pkg::DIV_CW-1:0]  r_cnt;
    logic [31:0]                 r_den;
    logic [31:0]                 r_rem_a;
    logic [31:0]                 r_quo_a;
    logic [31:0]                 r_per;
    logic [31:0]                 r_idle;
    logic [32:0]                 trial_a;
    logic                        ge_a;
    logic [31:0]                 n_rem_a;
    logic [63:0]                 idle_prod;
    logic                        last_step;

    assign trial_a   = {r_rem_a, r_quo_a[31]};
    assign ge_a      = (trial_a >= {1'b0, r_den});
    assign n_rem_a   = ge_a ? 32'(trial_a - {1'b0, r_den}) : trial_a[31:0];
    assign idle_prod = 64'(r_per) * 64'(emp_pkg::MS_RECIP);
    assign last_step = (r_cnt == emp_pkg::DIV_CW'(emp_pkg::DIV_STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && last_step;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (last_step) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Dividend shifts out the top while quotient bits shift in at the bottom.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den   <= i_den;
            r_rem_a <= '0;
            r_quo_a <= i_num;
            r_per   <= i_period;
        end else if (r_busy) begin
            r_rem_a <= n_rem_a;
            r_quo_a <= {r_quo_a[30:0], ge_a};
            r_idle  <= 32'(idle_prod >> emp_pkg::MS_RECIP_SHIFT);
        end
    end

    assign o_done    = r_done;
    assign o_power_q = r_quo_a;
    assign o_idle_q  = r_idle;

endmodule

### rtl/emp_back.sv
`timescale 1ns / 1ps
// Back end: runs one queued item through the divider, updates meter state, holds the result.
module emp_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [31:0]          i_cfg_wdata,
    input  logic                 i_q_valid,
    input  emp_pkg::t_item       i_q_item,
    output logic                 o_q_pop,
    output emp_pkg::t_div_ctl    o_div_ctl_start,
    input  emp_pkg::t_div_ctl    i_div_ctl_done,
    output logic [31:0]          o_div_num,
    output logic [31:0]          o_div_period,
    input  logic [31:0]          i_power_q,
    input  logic [31:0]          i_idle_q,
    output logic                 o_busy,
    output logic                 o_out_valid,
    output emp_pkg::t_result     o_out,
    input  logic                 i_pop
);

    emp_pkg::t_back_state  r_state;
    emp_pkg::t_back_state  n_state;
    logic [31:0]           r_numerator;
    logic [31:0]           r_total;
    logic [31:0]           n_total;
    logic [31:0]           r_day;
    logic [31:0]           n_day;
    logic [31:0]           r_month;
    logic [31:0]           n_month;
    logic [31:0]           r_last_ms;
    logic [31:0]           n_last_ms;
    logic [15:0]           r_last_power;
    logic [15:0]           n_last_power;
    logic [4:0]            r_prev_hour;
    logic [4:0]            n_prev_hour;
    logic [4:0]            r_prev_md;
    logic [4:0]            n_prev_md;
    emp_pkg::t_item        r_item;
    logic [31:0]           r_period;
    logic                  r_out_valid;
    logic                  n_out_valid;
    emp_pkg::t_result      r_out;
    emp_pkg::t_result      n_out;
    logic [31:0]           q_period;
    logic                  load;
    logic                  commit;
    logic                  is_pulse;
    logic                  do_midnight;
    logic                  day_hit;
    logic                  month_hit;

    assign q_period = i_q_item.now_ms - r_last_ms;

    always_comb begin
        n_state = r_state;
        load    = 1'b0;
        commit  = 1'b0;
        case (r_state)
            emp_pkg::S_IDLE: begin
                if (i_q_valid) begin
                    load    = 1'b1;
                    n_state = emp_pkg::S_DIV;
                end
            end
            emp_pkg::S_DIV: begin
                if (i_div_ctl_done.done) begin
                    n_state = emp_pkg::S_DONE;
                end
            end
            emp_pkg::S_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || i_pop) begin
                    commit  = 1'b1;
                    n_state = emp_pkg::S_IDLE;
                end
            end
            default: n_state = emp_pkg::S_IDLE;
        endcase
    end

    assign o_q_pop               = load;
    assign o_div_ctl_start.start = load;
    assign o_div_ctl_start.done  = 1'b0;
    assign o_div_num             = r_numerator;
    assign o_div_period          = q_period;
    assign o_busy                = (r_state != emp_pkg::S_IDLE);

    always_comb begin
        is_pulse     = (r_item.op == emp_pkg::OP_PULSE);
        n_total      = r_total;
        n_last_power = r_last_power;
        n_last_ms    = r_last_ms;
        if (is_pulse) begin
            n_total      = r_total + 32'd1;
            n_last_power = (r_period == '0) ? emp_pkg::SAT16 : emp_pkg::sat16(i_power_q);
            n_last_ms    = r_item.now_ms;
        end else if (r_item.op == emp_pkg::OP_PRESET) begin
            n_total = r_item.preset_count;
        end

        // Midnight latch sees the count after this pulse.
        do_midnight = r_item.time_valid
                      && (is_pulse || (r_item.op == emp_pkg::OP_POLL));
        day_hit     = do_midnight && (r_item.hour == emp_pkg::HOUR_MIDNIGHT)
                      && (r_prev_hour != emp_pkg::HOUR_MIDNIGHT);
        month_hit   = day_hit && (r_item.month_day == emp_pkg::DAY_FIRST)
                      && (r_prev_md != emp_pkg::DAY_FIRST);
        n_day       = day_hit ? n_total : r_day;
        n_month     = month_hit ? n_total : r_month;
        n_prev_hour = do_midnight ? r_item.hour : r_prev_hour;
        n_prev_md   = do_midnight ? r_item.month_day : r_prev_md;

        n_out.power_watts  = n_last_power;
        n_out.idle_seconds = emp_pkg::sat16(i_idle_q);
        n_out.total_pulses = n_total;
        n_out.day_pulses   = n_total - n_day;
        n_out.month_pulses = n_total - n_month;

        if (commit) begin
            n_out_valid = 1'b1;
        end else if (i_pop) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= emp_pkg::S_IDLE;
            r_numerator  <= emp_pkg::NUMERATOR_RESET;
            r_total      <= '0;
            r_day        <= '0;
            r_month      <= '0;
            r_last_ms    <= '0;
            r_last_power <= '0;
            r_prev_hour  <= '0;
            r_prev_md    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_numerator <= i_cfg_wdata;
            end
            if (commit) begin
                r_total      <= n_total;
                r_day        <= n_day;
                r_month      <= n_month;
                r_last_ms    <= n_last_ms;
                r_last_power <= n_last_power;
                r_prev_hour  <= n_prev_hour;
                r_prev_md    <= n_prev_md;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item   <= i_q_item;
            r_period <= q_period;
        end
        if (commit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

### sim/energy_pulse_meter_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for energy_pulse_meter_top: directed and random meter readings.
module energy_pulse_meter_top_test;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int NUM_PHASES   = 6;
    localparam int PHASE_ITEMS  = 258;
    localparam int QUIET_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 120;

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] now_ms;
        logic [4:0]  hour;
        logic [4:0]  month_day;
        logic        time_valid;
        logic [31:0] preset_count;
    } t_meter_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  i_kind = emp_pkg::KIND_POLL;
    logic [31:0] i_now_ms = '0;
    logic [4:0]  i_hour = '0;
    logic [4:0]  i_month_day = '0;
    logic        i_time_valid = 1'b0;
    logic [31:0] i_preset_count = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [15:0] o_power_watts;
    logic [15:0] o_idle_seconds;
    logic [31:0] o_total_pulses;
    logic [31:0] o_day_pulses;
    logic [31:0] o_month_pulses;
    logic        i_cfg_we = 1'b0;
    logic [31:0] i_cfg_wdata = '0;

    // predictor copy of the meter state
    logic [31:0] numerator = emp_pkg::NUMERATOR_RESET;
    logic [31:0] pulse_total = '0;
    logic [31:0] day_mark = '0;
    logic [31:0] month_mark = '0;
    logic [31:0] last_pulse_ms = '0;
    logic [15:0] last_power = '0;
    logic [4:0]  prev_hour = '0;
    logic [4:0]  prev_day = '0;

    t_meter_item       stim_items[$];
    emp_pkg::t_result  readings_due[$];
    t_meter_item       tx_item;
    int          burst_left = 0;
    int          gap_left = 0;
    int          rx_stall = 0;
    int          rx_mode = 0;
    int          rx_mode_left = 0;
    int          quiet_cycles = 0;
    int          errors = 0;
    int          checked = 0;
    int          cfg_writes = 0;
    int          kind_seen[4] = '{0, 0, 0, 0};

    // random clock generator state
    logic [31:0] gen_now = '0;
    logic [4:0]  gen_hour = 5'd20;
    logic [4:0]  gen_day = 5'd27;

    energy_pulse_meter_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_kind         (i_kind),
        .i_now_ms       (i_now_ms),
        .i_hour         (i_hour),
        .i_month_day    (i_month_day),
        .i_time_valid   (i_time_valid),
        .i_preset_count (i_preset_count),
        .empty          (empty),
        .pop            (pop),
        .o_power_watts  (o_power_watts),
        .o_idle_seconds (o_idle_seconds),
        .o_total_pulses (o_total_pulses),
        .o_day_pulses   (o_day_pulses),
        .o_month_pulses (o_month_pulses),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    function automatic logic [15:0] clip16(input logic [31:0] v);
        return (v > 32'd65535) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic void midnight_latch(input logic [4:0] hr, input logic [4:0] md);
        if (hr == emp_pkg::HOUR_MIDNIGHT && prev_hour != emp_pkg::HOUR_MIDNIGHT) begin
            day_mark = pulse_total;
            if (md == emp_pkg::DAY_FIRST && prev_day != emp_pkg::DAY_FIRST)
                month_mark = pulse_total;
        end
        prev_hour = hr;
        prev_day  = md;
    endfunction

    function automatic emp_pkg::t_result meter_predict(input t_meter_item it);
        emp_pkg::t_result res;
        logic [31:0]      period;
        period = it.now_ms - last_pulse_ms;
        res.idle_seconds = clip16(period / emp_pkg::MS_PER_SEC);
        case (it.kind)
            emp_pkg::KIND_PULSE: begin
                last_power  = (period == 0) ? emp_pkg::SAT16 : clip16(numerator / period);
                pulse_total = pulse_total + 32'd1;
                if (it.time_valid)
                    midnight_latch(it.hour, it.month_day);
                last_pulse_ms = it.now_ms;
            end
            emp_pkg::KIND_POLL: begin
                if (it.time_valid)
                    midnight_latch(it.hour, it.month_day);
            end
            emp_pkg::KIND_PRESET: begin
                pulse_total = it.preset_count;
            end
            default: begin
            end
        endcase
        res.power_watts  = last_power;
        res.total_pulses = pulse_total;
        res.day_pulses   = pulse_total - day_mark;
        res.month_pulses = pulse_total - month_mark;
        return res;
    endfunction

    function automatic t_meter_item reading(input logic [1:0] kind, input logic [31:0] now,
                                            input logic [4:0] hr, input logic [4:0] md,
                                            input logic valid, input logic [31:0] preset);
        t_meter_item it;
        it.kind = kind;
        it.now_ms = now;
        it.hour = hr;
        it.month_day = md;
        it.time_valid = valid;
        it.preset_count = preset;
        return it;
    endfunction

    // Mostly a plausible meter: time moves forward, the clock ticks through midnights.
    function automatic t_meter_item random_reading();
        t_meter_item it;
        int          r;
        logic [31:0] step;
        r = $urandom_range(0, 99);
        it.kind = (r < 70) ? emp_pkg::KIND_PULSE : (r < 88) ? emp_pkg::KIND_POLL :
                  (r < 95) ? emp_pkg::KIND_PRESET : KIND_UNUSED;
        case ($urandom_range(0, 9))
            0:             step = 32'd0;
            1:             step = $urandom_range(1, 20);
            2, 3, 4, 5, 6: step = $urandom_range(21, 5000);
            7:             step = $urandom_range(5001, 100000);
            8:             step = $urandom_range(100001, 100000000);
            default:       step = $urandom;
        endcase
        gen_now = gen_now + step;
        if ($urandom_range(0, 7) == 0)
            gen_hour = 5'd23;
        if ($urandom_range(0, 3) == 0) begin
            gen_hour = (gen_hour >= 5'd23) ? emp_pkg::HOUR_MIDNIGHT : gen_hour + 5'd1;
            if (gen_hour == emp_pkg::HOUR_MIDNIGHT)
                gen_day = ($urandom_range(0, 2) == 0 || gen_day >= 5'd31) ? emp_pkg::DAY_FIRST
                                                                           : gen_day + 5'd1;
        end
        it.now_ms = gen_now;
        it.hour = gen_hour;
        it.month_day = gen_day;
        it.time_valid = ($urandom_range(0, 9) != 0);
        if ($urandom_range(0, 19) == 0) begin
            it.hour = 5'($urandom_range(0, 31));
            it.month_day = 5'($urandom_range(0, 31));
        end
        case ($urandom_range(0, 3))
            0:       it.preset_count = 32'hFFFF_FFFF - $urandom_range(0, 3);
            1:       it.preset_count = $urandom_range(0, 100);
            default: it.preset_count = $urandom;
        endcase
        return it;
    endfunction

    task automatic wait_drained();
        do @(negedge i_clk);
        while (stim_items.size() != 0 || push || readings_due.size() != 0);
    endtask

    // driver: bursts of beats with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                readings_due.push_back(meter_predict(tx_item));
                kind_seen[tx_item.kind]++;
            end
            if (!(push && full)) begin
                if (gap_left != 0) begin
                    push <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (stim_items.size() != 0) begin
                    tx_item = stim_items.pop_front();
                    i_kind         <= tx_item.kind;
                    i_now_ms       <= tx_item.now_ms;
                    i_hour         <= tx_item.hour;
                    i_month_day    <= tx_item.month_day;
                    i_time_valid   <= tx_item.time_valid;
                    i_preset_count <= tx_item.preset_count;
                    push <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 100);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // monitor: check each popped beat, stall in modes that change over time
    always @(posedge i_clk) begin
        emp_pkg::t_result want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (readings_due.size() == 0) begin
                    $error("result with no reading pending: total_pulses %0d", o_total_pulses);
                    errors++;
                end else begin
                    want = readings_due.pop_front();
                    checked++;
                    if (o_power_watts !== want.power_watts) begin
                        $error("power_watts: expected %0d, got %0d",
                               want.power_watts, o_power_watts);
                        errors++;
                    end
                    if (o_idle_seconds !== want.idle_seconds) begin
                        $error("idle_seconds: expected %0d, got %0d",
                               want.idle_seconds, o_idle_seconds);
                        errors++;
                    end
                    if (o_total_pulses !== want.total_pulses) begin
                        $error("total_pulses: expected %0d, got %0d",
                               want.total_pulses, o_total_pulses);
                        errors++;
                    end
                    if (o_day_pulses !== want.day_pulses) begin
                        $error("day_pulses: expected %0d, got %0d",
                               want.day_pulses, o_day_pulses);
                        errors++;
                    end
                    if (o_month_pulses !== want.month_pulses) begin
                        $error("month_pulses: expected %0d, got %0d",
                               want.month_pulses, o_month_pulses);
                        errors++;
                    end
                end
            end
            if (rx_mode_left == 0) begin
                rx_mode <= $urandom_range(0, 2);
                rx_mode_left <= $urandom_range(100, 600);
            end else begin
                rx_mode_left <= rx_mode_left - 1;
            end
            if (rx_stall != 0) begin
                pop <= 1'b0;
                rx_stall <= rx_stall - 1;
            end else begin
                pop <= 1'b1;
                if (rx_mode != 0 && $urandom_range(0, 3) == 0)
                    rx_stall <= $urandom_range(1, (rx_mode == 1) ? 4 : 90);
            end
        end
    end

    // watchdog: too long without any beat means the block hung
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [31:0] settings[NUM_PHASES];
        settings = '{32'd0, 32'd1, 32'hFFFF_FFFF, $urandom, emp_pkg::NUMERATOR_RESET,
                     $urandom};

        // power edges at the reset numerator
        stim_items.push_back(reading(emp_pkg::KIND_POLL,   32'd0, 5'd0, 5'd1, 1'b1, 32'd0));
        stim_items.push_back(reading(emp_pkg::KIND_PULSE,  32'd0, 5'd3, 5'd2, 1'b0,
                                     32'hFFFF_FFFF));
        stim_items.push_back(reading(emp_pkg::KIND_PULSE,  32'd1, 5'd3, 5'd2, 1'b0, 32'd0));
        stim_items.push_back(reading(emp_pkg::KIND_PULSE,  32'd1001, 5'd3, 5'd2, 1'b0, 32'd0));
        stim_items.push_back(reading(emp_pkg::KIND_PULSE,  32'hFFFF_FFFF, 5'd31, 5'd31, 1'b0,
                                     32'd0));
        stim_items.push_back(reading(emp_pkg::KIND_PULSE,  32'd2000, 5'd3, 5'd2, 1'b0, 32'd0));
        // midnight and month rollover
        stim_items.push_back(reading(emp_pkg::KIND_POLL,   32'd3000, 5'd23, 5'd31, 1'b1, 32'd0));
        stim_items.push_back(reading(emp_pkg::KIND_PULSE,  32'd4000, 5'd0, 5'd1, 1'b1, 32'd0));
        stim_items.push_back(reading(emp_pkg::KIND_POLL,   32'd4100, 5'd0, 5'd1, 1'b1, 32'd0));
        stim_items.push_back(reading(emp_pkg::KIND_POLL,   32'd4200, 5'd5, 5'd9, 1'b0, 32'd0));
        stim_items.push_back(reading(emp_pkg::KIND_POLL,   32'd4300, 5'd0, 5'd1, 1'b1, 32'd0));
        stim_items.push_back(reading(emp_pkg::KIND_POLL,   32'd4400, 5'd31, 5'd0, 1'b1, 32'd0));
        stim_items.push_back(reading(emp_pkg::KIND_PULSE,  32'd4500, 5'd0, 5'd1, 1'b1, 32'd0));
        stim_items.push_back(reading(emp_pkg::KIND_POLL,   32'd4600, 5'd7, 5'd1, 1'b1, 32'd0));
        stim_items.push_back(reading(emp_pkg::KIND_POLL,   32'd4700, 5'd0, 5'd1, 1'b1, 32'd0));
        // preset skips the midnight check, unused kind touches nothing
        stim_items.push_back(reading(emp_pkg::KIND_PRESET, 32'd4800, 5'd12, 5'd15, 1'b1,
                                     32'hFFFF_FFFF));
        stim_items.push_back(reading(emp_pkg::KIND_POLL,   32'd4900, 5'd12, 5'd15, 1'b1, 32'd0));
        stim_items.push_back(reading(KIND_UNUSED,          32'd5000, 5'd0, 5'd1, 1'b1, 32'd7));
        stim_items.push_back(reading(emp_pkg::KIND_PULSE,  32'd5100, 5'd12, 5'd15, 1'b0, 32'd0));
        stim_items.push_back(reading(emp_pkg::KIND_POLL,   32'd5200, 5'd0, 5'd1, 1'b1, 32'd0));
        stim_items.push_back(reading(emp_pkg::KIND_PRESET, 32'd5300, 5'd0, 5'd1, 1'b0, 32'd0));
        stim_items.push_back(reading(emp_pkg::KIND_POLL,   32'd70005100, 5'd1, 5'd1, 1'b1,
                                     32'd0));
        stim_items.push_back(reading(emp_pkg::KIND_PULSE,  32'd5100, 5'd1, 5'd1, 1'b1, 32'd0));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++) begin
            // block is idle here: nothing queued, every result popped
            @(posedge i_clk);
            i_cfg_we <= 1'b1;
            i_cfg_wdata <= settings[p];
            @(posedge i_clk);
            i_cfg_we <= 1'b0;
            numerator = settings[p];
            cfg_writes++;
            @(negedge i_clk);
            for (int n = 0; n < PHASE_ITEMS; n++)
                stim_items.push_back(random_reading());
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (!empty) begin
            $error("result left in the block with no reading pending");
            errors++;
        end
        $display("Readings: %0d pulses, %0d polls, %0d presets, %0d unused kind",
                 kind_seen[emp_pkg::KIND_PULSE], kind_seen[emp_pkg::KIND_POLL],
                 kind_seen[emp_pkg::KIND_PRESET], kind_seen[KIND_UNUSED]);
        $display("%0d results checked over %0d numerator settings (0, 1, all ones); %0d mismatches",
                 checked, cfg_writes, errors);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
